>>> sv/bpc_pkg.sv
package bpc_pkg;

    // key bits of the port that carry buttons
    localparam logic [7:0]  KEY_PORT_MASK = 8'h27;
    localparam int unsigned BEEP_WINDOW   = 5;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_ACTIVE_LOW     = 3'd0,
        REG_SHORT_TICKS    = 3'd1,
        REG_LONG_TICKS     = 3'd2,
        REG_SHORT_BEEP_LEN = 3'd3,
        REG_LONG_BEEP_LEN  = 3'd4
    } reg_idx_t;

    // reset values of the configuration
    localparam logic        RST_ACTIVE_LOW     = 1'b1;
    localparam logic [15:0] RST_SHORT_TICKS    = 16'd50;
    localparam logic [15:0] RST_LONG_TICKS     = 16'd1000;
    localparam logic [9:0]  RST_SHORT_BEEP_LEN = 10'd80;
    localparam logic [9:0]  RST_LONG_BEEP_LEN  = 10'd280;

    // press classes
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_SHORT = 2'd1,
        KIND_LONG  = 2'd2
    } press_kind_t;

    typedef struct packed {
        logic        active_low;
        logic [15:0] short_ticks;
        logic [15:0] long_ticks;
        logic [9:0]  short_beep_len;
        logic [9:0]  long_beep_len;
    } bpc_cfg_t;

    typedef struct packed {
        logic [5:0]  held_mask;
        logic [15:0] hold_count;
        logic        beep_on;
        logic [9:0]  beep_len;
        logic [9:0]  beep_count;
    } bpc_state_t;

    typedef struct packed {
        press_kind_t press_kind;
        logic [5:0]  key_mask;
        logic        buzzer;
    } bpc_result_t;

endpackage

>>> sv/button_press_classifier.sv
// Button press classifier: one word per millisecond tick carries the raw button
// port byte, and exactly one result word comes back for each. A word is taken in
// every cycle while the result side keeps up; each word passes through the input
// register, then the combinational classify step into the output register. A
// stalled result side holds the result register, and the input stalls once the
// input register is also full. A result reports the press class (bounce, short,
// long) and the latched key mask on the tick of release, plus the buzzer level
// after that tick. Configuration must be written through cfg_wr_en/cfg_addr/
// cfg_wdata only while no word is in flight (the block does not enforce this);
// it resets to active low, 50 and 1000 ticks, and 80 and 280 tick buzzer pulses.
module button_press_classifier
    import bpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] port_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] press_kind, [7:2] key_mask, [8] buzzer
);

    bpc_cfg_t    cfg;
    bpc_state_t  state_reg;
    bpc_state_t  state_next;
    bpc_result_t step_res;
    bpc_result_t res_reg;
    logic [7:0]  port_reg;
    logic        in_valid_reg;
    logic        in_valid_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        advance;
    logic        in_acc;

    bpc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bpc_step u_step (
        .cfg       (cfg),
        .state     (state_reg),
        .port_bits (port_reg),
        .state_nxt (state_next),
        .result    (step_res)
    );

    // pipeline handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_acc   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_acc) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            port_reg <= s_tdata;
        end
        if (advance) begin
            res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, res_reg.buzzer, res_reg.key_mask, res_reg.press_kind};

    // idle pulse keeps a zero count
    a_beep_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.beep_on |-> state_reg.beep_count == 10'd0)
        else $error("beep count nonzero while pulse off");

    // no press held means no count
    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.held_mask == 6'd0 |-> state_reg.hold_count == 16'd0)
        else $error("hold count nonzero with no press held");

    // a bounce or no press reports no keys
    a_kind_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.press_kind == KIND_NONE |-> res_reg.key_mask == 6'd0)
        else $error("key mask reported without a press");

    // buzzer in a result follows the pulse state it left
    a_buzzer: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> res_reg.buzzer == state_reg.beep_on)
        else $error("buzzer level differs from pulse state");

endmodule

>>> sv/bpc_cfg_regs.sv
module bpc_cfg_regs
    import bpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    output bpc_cfg_t    cfg
);

    bpc_cfg_t cfg_reg;
    bpc_cfg_t cfg_next;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ACTIVE_LOW:     cfg_next.active_low     = cfg_wdata[0];
                REG_SHORT_TICKS:    cfg_next.short_ticks    = cfg_wdata;
                REG_LONG_TICKS:     cfg_next.long_ticks     = cfg_wdata;
                REG_SHORT_BEEP_LEN: cfg_next.short_beep_len = cfg_wdata[9:0];
                REG_LONG_BEEP_LEN:  cfg_next.long_beep_len  = cfg_wdata[9:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_low     <= RST_ACTIVE_LOW;
            cfg_reg.short_ticks    <= RST_SHORT_TICKS;
            cfg_reg.long_ticks     <= RST_LONG_TICKS;
            cfg_reg.short_beep_len <= RST_SHORT_BEEP_LEN;
            cfg_reg.long_beep_len  <= RST_LONG_BEEP_LEN;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/bpc_step.sv
module bpc_step
    import bpc_pkg::*;
(
    input  bpc_cfg_t    cfg,
    input  bpc_state_t  state,
    input  logic [7:0]  port_bits,
    output bpc_state_t  state_nxt,
    output bpc_result_t result
);

    logic [7:0]  port_pol;
    logic [7:0]  port_masked;
    logic [5:0]  keys;
    logic [15:0] count_inc;
    logic [16:0] short_end;
    logic [16:0] long_end;
    logic        win_short;
    logic        win_long;

    // polarity and key mask
    assign port_pol    = cfg.active_low ? ~port_bits : port_bits;
    assign port_masked = port_pol & KEY_PORT_MASK;
    assign keys        = port_masked[5:0];

    // saturating hold counter and threshold windows on the new count
    assign count_inc = (state.hold_count != COUNT_MAX) ? state.hold_count + 16'd1
                                                         : state.hold_count;
    assign short_end = {1'b0, cfg.short_ticks} + 17'(BEEP_WINDOW);
    assign long_end  = {1'b0, cfg.long_ticks} + 17'(BEEP_WINDOW);
    assign win_short = (count_inc >= cfg.short_ticks) && ({1'b0, count_inc} < short_end);
    assign win_long  = (count_inc >= cfg.long_ticks) && ({1'b0, count_inc} < long_end);

    always_comb begin
        state_nxt = state;
        result.press_kind = KIND_NONE;
        result.key_mask   = 6'd0;

        // running pulse steps first
        if (state.beep_on) begin
            if (state.beep_count < state.beep_len) begin
                state_nxt.beep_count = state.beep_count + 10'd1;
            end else begin
                state_nxt.beep_on    = 1'b0;
                state_nxt.beep_count = 10'd0;
            end
        end

        if (state.held_mask == 6'd0) begin
            // idle, or a press starts
            if (keys != 6'd0) begin
                state_nxt.held_mask = keys;
            end
        end else if (keys == 6'd0) begin
            // release: classify and clear
            if (state.hold_count < cfg.short_ticks) begin
                result.press_kind = KIND_NONE;
            end else if (state.hold_count >= cfg.long_ticks) begin
                result.press_kind = KIND_LONG;
                result.key_mask   = state.held_mask;
            end else begin
                result.press_kind = KIND_SHORT;
                result.key_mask   = state.held_mask;
            end
            state_nxt.held_mask  = 6'd0;
            state_nxt.hold_count = 16'd0;
        end else begin
            // still held: count and start a pulse in a window
            state_nxt.hold_count = count_inc;
            if (win_short && !state_nxt.beep_on) begin
                state_nxt.beep_len   = cfg.short_beep_len;
                state_nxt.beep_on    = (cfg.short_beep_len != 10'd0);
                state_nxt.beep_count = (cfg.short_beep_len != 10'd0) ? 10'd1 : 10'd0;
            end
            if (win_long && !state_nxt.beep_on) begin
                state_nxt.beep_len   = cfg.long_beep_len;
                state_nxt.beep_on    = (cfg.long_beep_len != 10'd0);
                state_nxt.beep_count = (cfg.long_beep_len != 10'd0) ? 10'd1 : 10'd0;
            end
        end

        result.buzzer = state_nxt.beep_on;
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import bpc_pkg::*;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr  = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;    // [7:0] port_bits
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;           // [1:0] press_kind, [7:2] key_mask, [8] buzzer

    button_press_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // run limit
    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // idling percentages for each side
    int unsigned send_idle_pct = 34;
    int unsigned recv_idle_pct = 49;

    // shadow of the configuration
    logic        invert_cfg     = RST_ACTIVE_LOW;
    logic [15:0] short_cfg      = RST_SHORT_TICKS;
    logic [15:0] long_cfg       = RST_LONG_TICKS;
    logic [9:0]  short_blen_cfg = RST_SHORT_BEEP_LEN;
    logic [9:0]  long_blen_cfg  = RST_LONG_BEEP_LEN;

    // shadow of the press and buzzer state
    logic [5:0]  held_keys  = '0;
    logic [15:0] held_ticks = '0;
    logic        buzz_on    = 1'b0;
    logic [9:0]  buzz_len   = '0;
    logic [9:0]  buzz_cnt   = '0;

    bpc_result_t pending_reports[$];

    int unsigned ticks_sent     = 0;
    int unsigned reports_seen   = 0;
    int unsigned mismatch_count = 0;
    int unsigned bounce_count   = 0;
    int unsigned short_count    = 0;
    int unsigned long_count     = 0;
    int unsigned buzz_ticks     = 0;
    int unsigned settings_used  = 0;

    // one tick of the running buzzer pulse
    task automatic buzz_step();
        if (buzz_cnt < buzz_len) begin
            buzz_cnt = buzz_cnt + 10'd1;
        end else begin
            buzz_on  = 1'b0;
            buzz_cnt = '0;
        end
    endtask

    task automatic buzz_start(input logic [9:0] len);
        if (!buzz_on) begin
            buzz_on  = 1'b1;
            buzz_len = len;
        end
        buzz_step();
    endtask

    // count lies in the five ticks starting at a threshold
    function automatic logic near_thr(input logic [15:0] cnt, input logic [15:0] thr);
        int unsigned c;
        int unsigned t;
        c = 32'(cnt);
        t = 32'(thr);
        return (c >= t) && (c < t + BEEP_WINDOW);
    endfunction

    // classify one port sample and queue the report it yields
    task automatic classify_tick(input logic [7:0] port);
        logic [7:0]  keys;
        bpc_result_t rep;
        keys = (invert_cfg ? ~port : port) & KEY_PORT_MASK;
        rep  = '0;
        if (buzz_on) buzz_step();
        if (keys != 8'd0 || held_keys != 6'd0) begin
            if (held_keys == 6'd0) begin
                held_keys = keys[5:0];
            end else if (keys == 8'd0) begin
                if (held_ticks < short_cfg) begin
                    rep.press_kind = KIND_NONE;
                    bounce_count++;
                end else if (held_ticks >= long_cfg) begin
                    rep.press_kind = KIND_LONG;
                    rep.key_mask   = held_keys;
                    long_count++;
                end else begin
                    rep.press_kind = KIND_SHORT;
                    rep.key_mask   = held_keys;
                    short_count++;
                end
                held_keys  = '0;
                held_ticks = '0;
            end else begin
                if (held_ticks != COUNT_MAX) held_ticks = held_ticks + 16'd1;
                if (near_thr(held_ticks, short_cfg) && !buzz_on) buzz_start(short_blen_cfg);
                if (near_thr(held_ticks, long_cfg) && !buzz_on) buzz_start(long_blen_cfg);
            end
        end
        rep.buzzer = buzz_on;
        if (buzz_on) buzz_ticks++;
        pending_reports.push_back(rep);
    endtask

    // result side backpressure
    always @(posedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each result word with the oldest pending report
    always @(posedge aclk) begin : check_reports
        bpc_result_t got;
        bpc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.press_kind = press_kind_t'(m_tdata[1:0]);
            got.key_mask   = m_tdata[7:2];
            got.buzzer     = m_tdata[8];
            if (pending_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result word %0d arrived with nothing pending", reports_seen);
            end else begin
                want = pending_reports.pop_front();
                if (got.press_kind !== want.press_kind || got.key_mask !== want.key_mask ||
                    got.buzzer !== want.buzzer) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("word %0d: kind %0d/%0d mask %h/%h buzzer %b/%b (exp/got)",
                                 reports_seen, want.press_kind, got.press_kind,
                                 want.key_mask, got.key_mask, want.buzzer, got.buzzer);
                end
            end
            reports_seen++;
        end
    end

    // send one port word, with random sender gaps
    task automatic send_word(input logic [7:0] port);
        int unsigned gap;
        gap = 0;
        while (gap < 8 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= port;
        do @(posedge aclk); while (!s_tready);
        ticks_sent++;
        classify_tick(port);
    endtask

    // build a port byte for the given keys under the current polarity
    task automatic send_keys(input logic [7:0] keys);
        logic [7:0] junk;
        junk = 8'($urandom);
        send_word((junk & ~KEY_PORT_MASK) |
                  ((invert_cfg ? ~keys : keys) & KEY_PORT_MASK));
    endtask

    function automatic logic [7:0] rand_keys();
        logic [7:0] k;
        do k = 8'($urandom) & KEY_PORT_MASK; while (k == 8'd0);
        return k;
    endfunction

    function automatic logic [9:0] rand_beep_len();
        case ($urandom_range(9))
            0:       return 10'd0;
            1:       return 10'd1023;
            default: return 10'($urandom_range(1, 12));
        endcase
    endfunction

    // stop sending and let every pending report come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic apply_settings(input logic al, input logic [15:0] st,
                                  input logic [15:0] lt, input logic [9:0] sb,
                                  input logic [9:0] lb);
        wait_idle();
        write_reg(REG_ACTIVE_LOW, {15'd0, al});
        write_reg(REG_SHORT_TICKS, st);
        write_reg(REG_LONG_TICKS, lt);
        write_reg(REG_SHORT_BEEP_LEN, {6'd0, sb});
        write_reg(REG_LONG_BEEP_LEN, {6'd0, lb});
        cfg_wr_en      <= 1'b0;
        invert_cfg     = al;
        short_cfg      = st;
        long_cfg       = lt;
        short_blen_cfg = sb;
        long_blen_cfg  = lb;
        settings_used++;
    endtask

    // reset polarity and thresholds: all-high idle, all-low press, bounce
    task automatic test_reset_values();
        send_word(8'hFF);
        send_word(8'h00);
        send_word(8'h00);
        send_word(8'hFF);
    endtask

    // keys change while held, zero length pulse at the short threshold
    task automatic test_key_change();
        apply_settings(1'b0, 16'd2, 16'd4, 10'd0, 10'd3);
        send_word(8'h01);
        send_word(8'h24);
        send_word(8'hFF);
        send_word(8'hD8);
    endtask

    // overlapping windows: short pulse tried first, then the long one
    task automatic test_both_windows();
        apply_settings(1'b0, 16'd2, 16'd3, 10'd0, 10'd3);
        repeat (6) send_keys(8'h27);
        send_keys(8'h00);
    endtask

    // long threshold below short: bounce below short, else long
    task automatic test_swapped_thresholds();
        apply_settings(1'b1, 16'd3, 16'd1, 10'd1, 10'd0);
        repeat (3) send_keys(rand_keys());
        send_keys(8'h00);
        repeat (4) send_keys(rand_keys());
        send_keys(8'h00);
    endtask

    // widest settings: short threshold out of reach, longest pulse
    task automatic test_wide_settings();
        apply_settings(1'b1, 16'hFFFF, 16'd1, 10'd3, 10'd1023);
        repeat (20) send_keys(rand_keys());
        send_keys(8'h00);
    endtask

    // random presses around the thresholds, mixed with noise
    task automatic test_random_presses(input int unsigned n_ticks);
        int unsigned stop_at;
        int unsigned cfg_mark;
        int unsigned hold;
        int unsigned max_thr;
        logic [7:0]  keys;
        stop_at  = ticks_sent + n_ticks;
        cfg_mark = ticks_sent;
        apply_settings(1'($urandom), 16'($urandom_range(1, 10)), 16'($urandom_range(1, 14)),
                       rand_beep_len(), rand_beep_len());
        while (ticks_sent < stop_at) begin
            if (ticks_sent - cfg_mark >= 60) begin
                apply_settings(1'($urandom), 16'($urandom_range(1, 10)),
                               16'($urandom_range(1, 14)), rand_beep_len(), rand_beep_len());
                cfg_mark = ticks_sent;
            end
            if ($urandom_range(99) < 80) begin
                max_thr = 32'((short_cfg > long_cfg) ? short_cfg : long_cfg);
                repeat ($urandom_range(0, 2)) send_keys(8'h00);
                hold = $urandom_range(1, max_thr + 6);
                keys = rand_keys();
                repeat (hold) begin
                    if ($urandom_range(1) == 1) keys = rand_keys();
                    send_keys(keys);
                end
                send_keys(8'h00);
            end else begin
                repeat ($urandom_range(1, 4)) send_word(8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_key_change();
        test_both_windows();
        test_swapped_thresholds();

        test_random_presses(160);
        send_idle_pct = 49;
        recv_idle_pct = 34;
        test_random_presses(160);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_presses(160);

        test_wide_settings();
        wait_idle();

        $display("covered %0d ticks under %0d settings, %0d result words checked",
                 ticks_sent, settings_used, reports_seen);
        $display("presses: %0d bounces, %0d short, %0d long; buzzer on for %0d ticks",
                 bounce_count, short_count, long_count, buzz_ticks);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
